/* hdl/modified_utf8_to_utf8_core_assert.svh */
// assertion macros for the modified utf-8 converter
`ifndef MODIFIED_UTF8_TO_UTF8_CORE_ASSERT_SVH
`define MODIFIED_UTF8_TO_UTF8_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MU8_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MU8_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MU8_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define MU8_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hdl/mu8_pkg.sv */
// shared types and constants of the modified utf-8 to utf-8 converter
`default_nettype none

package mu8_pkg;

    localparam int unsigned PEND_DEPTH  = 6;
    localparam int unsigned MAX_RESULTS = 4;

    typedef logic [2:0] pcnt_t;
    typedef logic [2:0] rnum_t;

    localparam pcnt_t PCNT_FULL = 3'd6;

    // byte patterns
    localparam logic [7:0]  LEAD_ED     = 8'b1110_1101;
    localparam logic [3:0]  HI_SURR_NIB = 4'b1010;
    localparam logic [3:0]  LO_SURR_NIB = 4'b1011;
    localparam logic [7:0]  NUL_LEAD    = 8'hc0;
    localparam logic [7:0]  NUL_TRAIL   = 8'h80;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [7:0]  LEAD4_MARK  = 8'hf0;
    localparam logic [7:0]  CONT_MARK   = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       stream_end;
        logic       bad_input;
    } out_t;

    // entry 0 is the oldest held byte
    typedef logic [PEND_DEPTH-1:0][7:0] pend_t;

    typedef struct packed {
        pend_t bytes;
        pcnt_t cnt;
        logic  err;
    } st_t;

    // results of one input byte, entry 0 goes out first
    typedef struct packed {
        out_t [MAX_RESULTS-1:0] ent;
        rnum_t                  num;
    } rset_t;

endpackage

`default_nettype wire

/* hdl/mu8_step.sv */
// per-byte decode: append to the held bytes, decide sequences, build results
`default_nettype none

module mu8_step (
    input  mu8_pkg::st_t  st_cur,
    input  mu8_pkg::in_t  item,
    output mu8_pkg::st_t  st_nxt,
    output mu8_pkg::rset_t res
);

    typedef enum logic [2:0] {
        ACT_WAIT,
        ACT_ONE,
        ACT_TWO,
        ACT_THREE,
        ACT_PAIR,
        ACT_ERR
    } act_t;

    typedef struct packed {
        mu8_pkg::pend_t bytes;
        mu8_pkg::pcnt_t cnt;
    } buf_t;

    typedef struct packed {
        logic [mu8_pkg::MAX_RESULTS-1:0][7:0] b;
        mu8_pkg::rnum_t                       num;
        logic                                 bad;
    } grp_t;

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // one decision on the front of the held bytes
    function automatic act_t decide(input buf_t bf, input logic last);
        act_t       a;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        b0 = bf.bytes[0];
        b1 = bf.bytes[1];
        b2 = bf.bytes[2];
        b3 = bf.bytes[3];
        b4 = bf.bytes[4];
        b5 = bf.bytes[5];
        if (bf.cnt == 3'd0) begin
            a = ACT_WAIT;
        end else if (!b0[7]) begin
            a = ACT_ONE;
        end else if (b0[7:5] == 3'b110) begin
            if (bf.cnt < 3'd2)   a = last ? ACT_ERR : ACT_WAIT;
            else                 a = is_cont(b1) ? ACT_TWO : ACT_ERR;
        end else if (b0[7:4] == 4'b1110) begin
            if (bf.cnt < 3'd2)   a = last ? ACT_ERR : ACT_WAIT;
            else if (!is_cont(b1)) a = ACT_ERR;
            else if (bf.cnt < 3'd3) a = last ? ACT_ERR : ACT_WAIT;
            else if (!is_cont(b2)) a = ACT_ERR;
            else if (b0 != mu8_pkg::LEAD_ED || b1[7:4] != mu8_pkg::HI_SURR_NIB)
                a = ACT_THREE;
            else if (bf.cnt < 3'd4) a = last ? ACT_THREE : ACT_WAIT;
            else if (b3 != mu8_pkg::LEAD_ED) a = ACT_THREE;
            else if (bf.cnt < 3'd5) a = last ? ACT_THREE : ACT_WAIT;
            else if (b4[7:4] != mu8_pkg::LO_SURR_NIB) a = ACT_THREE;
            else if (bf.cnt < 3'd6) a = last ? ACT_THREE : ACT_WAIT;
            else a = is_cont(b5) ? ACT_PAIR : ACT_THREE;
        end else begin
            a = ACT_ERR;
        end
        return a;
    endfunction

    // bytes emitted by one decision
    function automatic grp_t emit(input buf_t bf, input act_t a);
        grp_t        g;
        logic [20:0] cp;
        g.b   = '0;
        g.num = '0;
        g.bad = 1'b0;
        cp = mu8_pkg::SUPP_BASE
           + {1'b0, bf.bytes[1][3:0], 16'h0000}
           + {5'b0, bf.bytes[2][5:0], 10'b0}
           + {11'b0, bf.bytes[4][3:0], 6'b0}
           + {15'b0, bf.bytes[5][5:0]};
        case (a)
            ACT_ONE: begin
                g.b[0] = bf.bytes[0];
                g.num  = 3'd1;
            end
            ACT_TWO: begin
                if (bf.bytes[0] == mu8_pkg::NUL_LEAD && bf.bytes[1] == mu8_pkg::NUL_TRAIL) begin
                    g.b[0] = 8'h00;
                    g.num  = 3'd1;
                end else begin
                    g.b[0] = bf.bytes[0];
                    g.b[1] = bf.bytes[1];
                    g.num  = 3'd2;
                end
            end
            ACT_THREE: begin
                g.b[0] = bf.bytes[0];
                g.b[1] = bf.bytes[1];
                g.b[2] = bf.bytes[2];
                g.num  = 3'd3;
            end
            ACT_PAIR: begin
                g.b[0] = mu8_pkg::LEAD4_MARK | {5'b0, cp[20:18]};
                g.b[1] = mu8_pkg::CONT_MARK | {2'b0, cp[17:12]};
                g.b[2] = mu8_pkg::CONT_MARK | {2'b0, cp[11:6]};
                g.b[3] = mu8_pkg::CONT_MARK | {2'b0, cp[5:0]};
                g.num  = 3'd4;
            end
            ACT_ERR: begin
                g.num = 3'd1;
                g.bad = 1'b1;
            end
            default: begin
                g.num = '0;
            end
        endcase
        return g;
    endfunction

    // remove the bytes a decision used
    function automatic buf_t drop(input buf_t bf, input act_t a);
        buf_t           r;
        mu8_pkg::pcnt_t k;
        case (a)
            ACT_ONE:   k = 3'd1;
            ACT_TWO:   k = 3'd2;
            ACT_THREE: k = 3'd3;
            ACT_PAIR:  k = 3'd6;
            default:   k = 3'd0;
        endcase
        r.bytes = bf.bytes >> {k, 3'b000};
        r.cnt   = (k >= bf.cnt) ? 3'd0 : bf.cnt - k;
        return r;
    endfunction

    buf_t           buf0;
    buf_t           buf1;
    buf_t           buf2;
    act_t           act0;
    act_t           act1;
    grp_t           grp0;
    grp_t           grp1;
    mu8_pkg::rnum_t total;
    logic           bad_any;
    logic           last;

    assign last = item.in_last;

    // append the new byte and run up to two decisions
    always_comb begin
        buf0.bytes = st_cur.bytes;
        buf0.cnt   = st_cur.cnt;
        if (st_cur.cnt < mu8_pkg::PCNT_FULL) begin
            buf0.bytes[st_cur.cnt] = item.in_byte;
            buf0.cnt               = st_cur.cnt + 3'd1;
        end
        act0 = decide(buf0, last);
        grp0 = emit(buf0, act0);
        buf1 = drop(buf0, act0);
        if (act0 == ACT_WAIT || act0 == ACT_ERR) begin
            act1 = ACT_WAIT;
        end else begin
            act1 = decide(buf1, last);
        end
        grp1 = emit(buf1, act1);
        buf2 = drop(buf1, act1);
    end

    assign total   = grp0.num + grp1.num;
    assign bad_any = grp0.bad | grp1.bad;

    // merge both groups into one result list and mark the ends
    always_comb begin
        mu8_pkg::rnum_t j;
        j = '0;
        res.ent = '0;
        for (int i = 0; i < mu8_pkg::MAX_RESULTS; i++) begin
            j = mu8_pkg::rnum_t'(i) - grp0.num;
            if (mu8_pkg::rnum_t'(i) < grp0.num) begin
                res.ent[i].out_byte  = grp0.b[i];
                res.ent[i].bad_input = grp0.bad;
            end else begin
                res.ent[i].out_byte  = grp1.b[j[1:0]];
                res.ent[i].bad_input = grp1.bad;
            end
            res.ent[i].run_end    = (mu8_pkg::rnum_t'(i + 1) == total);
            res.ent[i].stream_end = (mu8_pkg::rnum_t'(i + 1) == total) && (last || bad_any);
        end
        res.num = st_cur.err ? 3'd0 : total;
    end

    // next held state
    always_comb begin
        st_nxt.bytes = buf2.bytes;
        st_nxt.cnt   = buf2.cnt;
        st_nxt.err   = 1'b0;
        if (st_cur.err) begin
            st_nxt = st_cur;
            if (last) begin
                st_nxt = '0;
            end
        end else if (bad_any) begin
            st_nxt     = '0;
            st_nxt.err = !last;
        end else if (last) begin
            st_nxt = '0;
        end
    end

endmodule

`default_nettype wire

/* hdl/mu8_outq.sv */
// result buffer: holds the results of one byte and hands them out one per cycle while m_ready is high
`default_nettype none

module mu8_outq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  mu8_pkg::rset_t  res,
    output logic            load_ok,
    output logic            m_valid,
    input  logic            m_ready,
    output mu8_pkg::out_t   m_payload
);

    mu8_pkg::out_t [mu8_pkg::MAX_RESULTS-1:0] ent_reg;
    mu8_pkg::out_t [mu8_pkg::MAX_RESULTS-1:0] ent_next;
    mu8_pkg::rnum_t                           num_reg;
    mu8_pkg::rnum_t                           num_next;
    logic                                     pop;

    assign m_valid   = (num_reg != 3'd0);
    assign m_payload = ent_reg[0];
    assign pop       = m_valid && m_ready;
    // free now, or the last entry leaves in this transfer
    assign load_ok   = (num_reg == 3'd0) || (num_reg == 3'd1 && m_ready);

    // load a new list or shift out the delivered entry
    always_comb begin
        ent_next = ent_reg;
        num_next = num_reg;
        if (load) begin
            ent_next = res.ent;
            num_next = res.num;
        end else if (pop) begin
            ent_next = ent_reg >> $bits(mu8_pkg::out_t);
            num_next = num_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg <= '0;
        end else begin
            num_reg <= num_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

/* hdl/modified_utf8_to_utf8_core.sv */
// modified utf-8 to standard utf-8 converter, top level
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | mu8_pkg::in_t  (in_byte, in_last)
//   m_      | out | m_valid / m_ready  | mu8_pkg::out_t (out_byte, run_end, stream_end,
//           |     |                    |                 bad_input)
//
// a byte that causes several results holds the input side while the result buffer
// drains them, one entry per cycle while m_ready is high (up to four results, a
// surrogate pair gives four)
// a byte is registered in the input register and its results in the result buffer, which drives m_
// reset clears the held byte count, the error flag and both valid flags
// a stall on m_ready backs up through the result buffer into the input register
`default_nettype none

`include "modified_utf8_to_utf8_core_assert.svh"

module modified_utf8_to_utf8_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mu8_pkg::in_t   s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output mu8_pkg::out_t  m_payload
);

    mu8_pkg::in_t   in_reg;
    logic           in_valid_reg;
    logic           in_valid_next;
    mu8_pkg::st_t   st_reg;
    mu8_pkg::st_t   st_nxt;
    mu8_pkg::rset_t res;
    logic           load_ok;
    logic           load;

    // input register moves on when the result buffer can take its results
    assign load    = in_valid_reg && load_ok;
    assign s_ready = !in_valid_reg || load_ok;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            st_reg       <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (load) begin
                st_reg <= st_nxt;
            end
        end
    end

    // input payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
    end

    // decode logic
    mu8_step u_step (
        .st_cur (st_reg),
        .item   (in_reg),
        .st_nxt (st_nxt),
        .res    (res)
    );

    // result buffer
    mu8_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .res       (res),
        .load_ok   (load_ok),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // checks
    `MU8_ASSERT_IMPL(a_drop_silent, aclk, aresetn, load && st_reg.err, res.num == 3'd0,
        "byte after an error produced results")
    `MU8_ASSERT_NEXT(a_last_clears, aclk, aresetn, load && in_reg.in_last,
        (st_reg.cnt == 3'd0) && !st_reg.err, "final byte did not clear the state")
    `MU8_ASSERT_IMPL(a_bad_is_end, aclk, aresetn, m_valid && m_payload.bad_input,
        m_payload.run_end && m_payload.stream_end && (m_payload.out_byte == 8'h00),
        "error result not closing the string")
    `MU8_ASSERT_IMPL(a_pend_bound, aclk, aresetn, in_valid_reg,
        st_reg.cnt < mu8_pkg::PCNT_FULL, "held byte count overflow")

endmodule

`default_nettype wire

/* sim/mu8_stream_checker.sv */
// result checker for the modified utf-8 converter: predicts every result and compares it
module mu8_stream_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  mu8_pkg::in_t    s_payload,
    input  logic            m_valid,
    input  logic            m_ready,
    input  mu8_pkg::out_t   m_payload,
    output int unsigned     fail_count,
    output int unsigned     due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // what the decoder does with the bytes at the head of the hold buffer
    typedef enum logic [2:0] {
        DEC_WAIT,
        DEC_ONE,
        DEC_TWO,
        DEC_THREE,
        DEC_PAIR,
        DEC_BAD
    } dec_t;

    // predictor state, oldest held byte in entry 0
    logic [7:0]  held [mu8_pkg::PEND_DEPTH];
    int unsigned held_cnt;
    bit          skip_to_end;

    mu8_pkg::out_t utf8_due_q [$];
    int unsigned   due_len;
    int unsigned   mismatches = 0;

    assign fail_count = mismatches;
    assign due_count  = due_len;

    function automatic bit is_trail(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic mu8_pkg::out_t data_result(input logic [7:0] b);
        mu8_pkg::out_t r;
        r          = '0;
        r.out_byte = b;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_decoder();
        foreach (held[i])
            held[i] = '0;
        held_cnt    = 0;
        skip_to_end = 1'b0;
    endtask

    task automatic drop_held(input int unsigned k);
        if (k >= held_cnt) begin
            held_cnt = 0;
        end else begin
            for (int i = 0; i + k < mu8_pkg::PEND_DEPTH; i++)
                held[i] = held[i + k];
            held_cnt -= k;
        end
    endtask

    // expected results of one input transfer
    task automatic convert_byte(input mu8_pkg::in_t it);
        mu8_pkg::out_t run_q [$];
        mu8_pkg::out_t bad;
        dec_t          act;
        logic [7:0]    b0;
        logic [20:0]   cp;
        bit            fin;
        int            tail;
        fin = it.in_last;
        // after an error everything up to and including the final byte is dropped
        if (skip_to_end) begin
            if (fin)
                clear_decoder();
            return;
        end
        if (held_cnt < mu8_pkg::PEND_DEPTH) begin
            held[held_cnt] = it.in_byte;
            held_cnt++;
        end
        while (held_cnt > 0) begin
            b0 = held[0];
            // classify the sequence at the head
            if (!b0[7]) begin
                act = DEC_ONE;
            end else if (b0[7:5] == 3'b110) begin
                if (held_cnt < 2)             act = fin ? DEC_BAD : DEC_WAIT;
                else                          act = is_trail(held[1]) ? DEC_TWO : DEC_BAD;
            end else if (b0[7:4] == 4'b1110) begin
                if (held_cnt < 2)             act = fin ? DEC_BAD : DEC_WAIT;
                else if (!is_trail(held[1]))  act = DEC_BAD;
                else if (held_cnt < 3)        act = fin ? DEC_BAD : DEC_WAIT;
                else if (!is_trail(held[2]))  act = DEC_BAD;
                else if (b0 != mu8_pkg::LEAD_ED || held[1][7:4] != mu8_pkg::HI_SURR_NIB)
                                              act = DEC_THREE;
                else if (held_cnt < 4)        act = fin ? DEC_THREE : DEC_WAIT;
                else if (held[3] != mu8_pkg::LEAD_ED)
                                              act = DEC_THREE;
                else if (held_cnt < 5)        act = fin ? DEC_THREE : DEC_WAIT;
                else if (held[4][7:4] != mu8_pkg::LO_SURR_NIB)
                                              act = DEC_THREE;
                else if (held_cnt < 6)        act = fin ? DEC_THREE : DEC_WAIT;
                else                          act = is_trail(held[5]) ? DEC_PAIR : DEC_THREE;
            end else begin
                act = DEC_BAD;
            end

            if (act == DEC_WAIT)
                break;

            // error: bytes already decided go first, then one error result
            if (act == DEC_BAD) begin
                bad            = '0;
                bad.run_end    = 1'b1;
                bad.stream_end = 1'b1;
                bad.bad_input  = 1'b1;
                foreach (run_q[i])
                    utf8_due_q.insert(utf8_due_q.size(), run_q[i]);
                utf8_due_q.insert(utf8_due_q.size(), bad);
                if (fin) begin
                    clear_decoder();
                end else begin
                    held_cnt    = 0;
                    skip_to_end = 1'b1;
                end
                return;
            end

            case (act)
                DEC_ONE: begin
                    run_q.insert(run_q.size(), data_result(b0));
                    drop_held(1);
                end
                DEC_TWO: begin
                    // encoded zero collapses to one zero byte
                    if (b0 == mu8_pkg::NUL_LEAD && held[1] == mu8_pkg::NUL_TRAIL) begin
                        run_q.insert(run_q.size(), data_result(8'h00));
                    end else begin
                        run_q.insert(run_q.size(), data_result(b0));
                        run_q.insert(run_q.size(), data_result(held[1]));
                    end
                    drop_held(2);
                end
                DEC_THREE: begin
                    run_q.insert(run_q.size(), data_result(b0));
                    run_q.insert(run_q.size(), data_result(held[1]));
                    run_q.insert(run_q.size(), data_result(held[2]));
                    drop_held(3);
                end
                default: begin
                    // surrogate pair becomes one four-byte sequence
                    cp = mu8_pkg::SUPP_BASE
                       + (21'(held[1][3:0]) << 16)
                       + (21'(held[2][5:0]) << 10)
                       + (21'(held[4][3:0]) << 6)
                       + 21'(held[5][5:0]);
                    run_q.insert(run_q.size(),
                                 data_result(mu8_pkg::LEAD4_MARK | 8'(cp[20:18])));
                    run_q.insert(run_q.size(),
                                 data_result(mu8_pkg::CONT_MARK | 8'(cp[17:12])));
                    run_q.insert(run_q.size(),
                                 data_result(mu8_pkg::CONT_MARK | 8'(cp[11:6])));
                    run_q.insert(run_q.size(),
                                 data_result(mu8_pkg::CONT_MARK | 8'(cp[5:0])));
                    drop_held(6);
                end
            endcase
        end

        // mark the end of this byte's run and of the string
        if (run_q.size() > 0) begin
            tail = run_q.size() - 1;
            run_q[tail].run_end = 1'b1;
            if (fin)
                run_q[tail].stream_end = 1'b1;
        end
        foreach (run_q[i])
            utf8_due_q.insert(utf8_due_q.size(), run_q[i]);
        if (fin)
            clear_decoder();
    endtask

    task automatic check_result(input mu8_pkg::out_t got, input mu8_pkg::out_t want);
        if (got.out_byte !== want.out_byte)
            flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                    got.out_byte, want.out_byte));
        if (got.run_end !== want.run_end)
            flag_mismatch($sformatf("run_end %b, expected %b (byte %02h)",
                                    got.run_end, want.run_end, want.out_byte));
        if (got.stream_end !== want.stream_end)
            flag_mismatch($sformatf("stream_end %b, expected %b (byte %02h)",
                                    got.stream_end, want.stream_end, want.out_byte));
        if (got.bad_input !== want.bad_input)
            flag_mismatch($sformatf("bad_input %b, expected %b (byte %02h)",
                                    got.bad_input, want.bad_input, want.out_byte));
    endtask

    // result transfers are checked before the input transfer of the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_decoder();
            utf8_due_q.delete();
            due_len <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (utf8_due_q.size() == 0)
                    flag_mismatch($sformatf("result %02h with nothing due",
                                            m_payload.out_byte));
                else
                    check_result(m_payload, utf8_due_q.pop_front());
            end
            if (s_valid && s_ready)
                convert_byte(s_payload);
            due_len <= utf8_due_q.size();
        end
    end

endmodule

/* sim/tb_modified_utf8_to_utf8_core.sv */
// testbench top for the modified utf-8 converter: stimulus, flow control and verdict
module tb_modified_utf8_to_utf8_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 470;
    localparam int unsigned CALM_TAIL    = 60;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    mu8_pkg::in_t  s_payload = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    mu8_pkg::out_t m_payload;
    int unsigned   fail_count;
    int unsigned   due_count;

    bit            calm       = 1'b0;
    int unsigned   ready_left = 0;
    mu8_pkg::in_t  byte_plan [$];

    always #10 aclk = ~aclk;

    modified_utf8_to_utf8_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    mu8_stream_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // one string, final byte flagged
    task automatic push_string(input logic [7:0] seq [$]);
        mu8_pkg::in_t it;
        foreach (seq[i]) begin
            it.in_byte = seq[i];
            it.in_last = (i == seq.size() - 1);
            byte_plan.insert(byte_plan.size(), it);
        end
    endtask

    // random string, mostly well-formed sequences with some broken ones mixed in
    task automatic add_string();
        logic [7:0]  seq [$];
        int unsigned segs;
        bit          cut;
        segs = $urandom_range(1, 6);
        cut  = 1'b0;
        for (int n = 0; n < segs && !cut; n++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin
                    seq.insert(seq.size(), 8'($urandom_range(0, 127)));
                end
                4, 5, 6: begin
                    seq.insert(seq.size(), {3'b110, 5'($urandom)});
                    seq.insert(seq.size(), cont_byte());
                end
                7: begin
                    seq.insert(seq.size(), mu8_pkg::NUL_LEAD);
                    seq.insert(seq.size(), mu8_pkg::NUL_TRAIL);
                end
                8, 9, 10: begin
                    seq.insert(seq.size(), {4'b1110, 4'($urandom)});
                    seq.insert(seq.size(), cont_byte());
                    seq.insert(seq.size(), cont_byte());
                end
                11: begin
                    // lone high surrogate
                    seq.insert(seq.size(), mu8_pkg::LEAD_ED);
                    seq.insert(seq.size(), {mu8_pkg::HI_SURR_NIB, 4'($urandom)});
                    seq.insert(seq.size(), cont_byte());
                end
                12, 13, 14: begin
                    seq.insert(seq.size(), mu8_pkg::LEAD_ED);
                    seq.insert(seq.size(), {mu8_pkg::HI_SURR_NIB, 4'($urandom)});
                    seq.insert(seq.size(), cont_byte());
                    seq.insert(seq.size(), mu8_pkg::LEAD_ED);
                    seq.insert(seq.size(), {mu8_pkg::LO_SURR_NIB, 4'($urandom)});
                    seq.insert(seq.size(), cont_byte());
                end
                15: begin
                    // pair cut short by the end of the string
                    seq.insert(seq.size(), mu8_pkg::LEAD_ED);
                    seq.insert(seq.size(), {mu8_pkg::HI_SURR_NIB, 4'($urandom)});
                    seq.insert(seq.size(), cont_byte());
                    if ($urandom_range(0, 3) != 0)
                        seq.insert(seq.size(), mu8_pkg::LEAD_ED);
                    if ($urandom_range(0, 1) != 0)
                        seq.insert(seq.size(), {mu8_pkg::LO_SURR_NIB, 4'($urandom)});
                    cut = 1'b1;
                end
                16: begin
                    seq.insert(seq.size(), 8'($urandom));
                end
                17: begin
                    // bad continuation
                    if ($urandom_range(0, 1) != 0) begin
                        seq.insert(seq.size(), {3'b110, 5'($urandom)});
                    end else begin
                        seq.insert(seq.size(), {4'b1110, 4'($urandom)});
                        if ($urandom_range(0, 1) != 0)
                            seq.insert(seq.size(), cont_byte());
                    end
                    if ($urandom_range(0, 1) != 0)
                        seq.insert(seq.size(), 8'($urandom_range(0, 127)));
                    else
                        seq.insert(seq.size(), {2'b11, 6'($urandom)});
                end
                18: begin
                    // multi-byte lead left open at the end of the string
                    if ($urandom_range(0, 1) != 0) begin
                        seq.insert(seq.size(), {3'b110, 5'($urandom)});
                    end else begin
                        seq.insert(seq.size(), {4'b1110, 4'($urandom)});
                        if ($urandom_range(0, 1) != 0)
                            seq.insert(seq.size(), cont_byte());
                    end
                    cut = 1'b1;
                end
                default: begin
                    // bad lead
                    if ($urandom_range(0, 1) != 0)
                        seq.insert(seq.size(), cont_byte());
                    else
                        seq.insert(seq.size(), {4'b1111, 4'($urandom)});
                end
            endcase
        end
        push_string(seq);
    endtask

    // result side flow control: ready and stall bursts, always ready when calm
    always @(posedge aclk) begin
        if (calm) begin
            m_ready    <= 1'b1;
            ready_left = 0;
        end else if (ready_left != 0) begin
            ready_left--;
        end else if ($urandom_range(0, 2) != 0) begin
            m_ready    <= 1'b1;
            ready_left = $urandom_range(0, 30);
        end else begin
            m_ready    <= 1'b0;
            ready_left = $urandom_range(0, 16);
        end
    end

    // stimulus and verdict
    initial begin
        int unsigned directed_n;
        bit          next_calm;

        // directed strings
        push_string('{8'h00});
        push_string('{8'h7f, 8'hc0, 8'h80});
        push_string('{8'hc1, 8'hbf});
        push_string('{8'h80, 8'h41, 8'h41});
        push_string('{8'hff});
        push_string('{8'hed, 8'haf, 8'h80, 8'hed, 8'hb0, 8'hbf});
        push_string('{8'he2, 8'h41});
        push_string('{8'hed, 8'ha0, 8'h80, 8'hed});
        directed_n = byte_plan.size();

        while (byte_plan.size() < directed_n + RANDOM_ITEMS)
            add_string();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        next_calm = 1'b0;
        for (int idx = 0; idx < byte_plan.size(); idx++) begin
            // stretches without idling, and none at all near the end
            if (idx % 60 == 0)
                next_calm = ($urandom_range(0, 3) == 0);
            if (idx + CALM_TAIL >= byte_plan.size())
                next_calm = 1'b1;
            calm <= next_calm;

            if (idx == directed_n || idx == byte_plan.size() / 2) begin
                // hold off until every pending result has come out
                s_valid <= 1'b0;
                @(posedge aclk);
                while (due_count != 0)
                    @(posedge aclk);
            end else if (!next_calm && $urandom_range(0, 4) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 17))
                    @(posedge aclk);
            end

            s_valid   <= 1'b1;
            s_payload <= byte_plan[idx];
            do
                @(posedge aclk);
            while (!(s_valid && s_ready));
        end
        s_valid <= 1'b0;

        // drain, then wait for anything stray
        @(posedge aclk);
        while (due_count != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fail_count == 0)
            $display("tb_modified_utf8_to_utf8_core OK");
        else
            $display("tb_modified_utf8_to_utf8_core NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #(10_000_000);
        $display("tb_modified_utf8_to_utf8_core NOT OK");
        $finish;
    end

endmodule

/* modified_utf8_to_utf8_core.f */
+incdir+hdl
hdl/mu8_pkg.sv
hdl/mu8_step.sv
hdl/mu8_outq.sv
hdl/modified_utf8_to_utf8_core.sv
sim/mu8_stream_checker.sv
sim/tb_modified_utf8_to_utf8_core.sv
